// File: rtl/core/pid_feedforward_position_loop_assert.svh
// Assertion macros shared by the position loop RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using module.
`ifndef PID_FEEDFORWARD_POSITION_LOOP_ASSERT_SVH
`define PID_FEEDFORWARD_POSITION_LOOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PFPL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every clock edge, reset included.
`define PFPL_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: rtl/core/pfpl_pkg.sv
// Types, widths, register codes and the rounding function of the position loop.
// Has no dependencies; every module of the block imports it.
package pfpl_pkg;

	localparam int SIG_W     = 24;
	localparam int GAIN_W    = 24;
	localparam int ERR_W     = SIG_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int GAIN_FRAC = 12;
	localparam int PROD_W    = GAIN_W + DIFF_W;
	localparam int TERM_W    = PROD_W - GAIN_FRAC;
	localparam int INT_W     = 16;
	localparam int INT_LIMIT = 32512;
	localparam int ACC_W     = TERM_W + 1;
	localparam int SUM_W     = TERM_W + 2;
	localparam int DRIVE_W   = 32;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 4;

	localparam logic [1:0] REG_GAIN_FF = 2'd0;
	localparam logic [1:0] REG_GAIN_P  = 2'd1;
	localparam logic [1:0] REG_GAIN_I  = 2'd2;
	localparam logic [1:0] REG_GAIN_D  = 2'd3;

	typedef logic signed [SIG_W-1:0]   sig_t;
	typedef logic signed [GAIN_W-1:0]  gain_t;
	typedef logic signed [ERR_W-1:0]   perr_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [INT_W-1:0]   int_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

	typedef struct packed {
		gain_t ff;
		gain_t p;
		gain_t i;
		gain_t d;
	} gains_t;

	typedef struct packed {
		perr_t e;
		perr_t ve;
		diff_t diff;
		logic  flip;
		logic  restart;
	} err_stage_t;

	typedef struct packed {
		prod_t ff;
		prod_t p;
		prod_t i;
		prod_t d;
		logic  flip;
		logic  restart;
	} prod_stage_t;

	typedef struct packed {
		term_t ff;
		term_t p;
		term_t d;
		int_t  i;
	} term_stage_t;

	// Q.20 product back to Q.8, rounding half toward positive infinity.
	function automatic term_t round_q8(prod_t x);
		prod_t t;
		t = x + prod_t'(1 << (GAIN_FRAC - 1));
		return t[PROD_W-1:GAIN_FRAC];
	endfunction

endpackage

// File: rtl/core/pid_feedforward_position_loop.sv
// PID position loop with velocity feedforward: top level, handshake control and output sum.
// Depends on pfpl_pkg, pfpl_apb, pfpl_err, pfpl_mul, pfpl_intg and the assertion macros.
//
// One request carries a profile point (target position and velocity), the measured
// position and velocity, and a restart flag. Each request yields one drive value,
// the sum of feedforward, proportional, integral and derivative terms, saturated to
// 32 bits. Both channels use valid and stall; a request is taken when req_valid is
// high and req_stall is low, and a drive value leaves when drive_valid is high and
// drive_stall is low.
// From the accepting edge to drive_valid, the request passes the
// input, error, multiplier, rounding and integral, and output registers.
// A new request can be taken every cycle unless req_stall is high. The integral and
// previous error are kept in the rounding and error stages and are updated once per
// request as it passes. When the receiver stalls, the result waits in the output register
// and the stages behind it keep filling; req_stall rises only once all five stages are full.
// Reset clears the gains, the integral, the previous error and all valid bits.
// Gains are to be written over the APB-style port while no request is in flight; not enforced.
`include "pid_feedforward_position_loop_assert.svh"

module pid_feedforward_position_loop (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfpl_pkg::ADDR_W-1:0]  paddr,
	input  logic [pfpl_pkg::DATA_W-1:0]  pwdata,
	output logic [pfpl_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  pfpl_pkg::sig_t               target_position,
	input  pfpl_pkg::sig_t               target_velocity,
	input  pfpl_pkg::sig_t               measured_position,
	input  pfpl_pkg::sig_t               measured_velocity,
	input  logic                         restart,
	output logic                         drive_valid,
	input  logic                         drive_stall,
	output pfpl_pkg::drive_t             drive
);
	import pfpl_pkg::*;

	gains_t      gains;
	err_stage_t  err_s2;
	prod_stage_t prod_s3;
	term_stage_t term_s4;

	sig_t   tp_s1;
	sig_t   tv_s1;
	sig_t   mp_s1;
	sig_t   mv_s1;
	logic   restart_s1;

	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   valid_s4;
	logic   drive_valid_q;
	drive_t drive_q;

	logic   accept;
	logic   rdy_s1;
	logic   rdy_s2;
	logic   rdy_s3;
	logic   rdy_s4;
	logic   move_s1;
	logic   move_s2;
	logic   move_s3;
	logic   move_s4;
	sum_t   sum;
	drive_t sat;

	assign rdy_s4  = !drive_valid_q || !drive_stall;
	assign move_s4 = valid_s4 && rdy_s4;
	assign rdy_s3  = !valid_s4 || rdy_s4;
	assign move_s3 = valid_s3 && rdy_s3;
	assign rdy_s2  = !valid_s3 || rdy_s3;
	assign move_s2 = valid_s2 && rdy_s2;
	assign rdy_s1  = !valid_s2 || rdy_s2;
	assign move_s1 = valid_s1 && rdy_s1;
	assign req_stall = valid_s1 && !rdy_s1;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			drive_valid_q <= 1'b0;
		end else begin
			valid_s1      <= accept || (valid_s1 && !move_s1);
			valid_s2      <= move_s1 || (valid_s2 && !move_s2);
			valid_s3      <= move_s2 || (valid_s3 && !move_s3);
			valid_s4      <= move_s3 || (valid_s4 && !move_s4);
			drive_valid_q <= move_s4 || (drive_valid_q && drive_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tp_s1      <= target_position;
			tv_s1      <= target_velocity;
			mp_s1      <= measured_position;
			mv_s1      <= measured_velocity;
			restart_s1 <= restart;
		end
	end

	pfpl_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	pfpl_err u_err (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (move_s1),
		.target_position   (tp_s1),
		.target_velocity   (tv_s1),
		.measured_position (mp_s1),
		.measured_velocity (mv_s1),
		.restart           (restart_s1),
		.err_s2            (err_s2)
	);

	pfpl_mul u_mul (
		.clk     (clk),
		.en      (move_s2),
		.gains   (gains),
		.err_s2  (err_s2),
		.prod_s3 (prod_s3)
	);

	pfpl_intg u_intg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (move_s3),
		.prod_s3 (prod_s3),
		.term_s4 (term_s4)
	);

	assign sum = SUM_W'(term_s4.ff) + SUM_W'(term_s4.p) + SUM_W'(term_s4.d) +
		SUM_W'(term_s4.i);

	always_comb begin
		if ((&sum[SUM_W-1:DRIVE_W-1]) || !(|sum[SUM_W-1:DRIVE_W-1])) begin
			sat = sum[DRIVE_W-1:0];
		end else begin
			sat = {sum[SUM_W-1], {(DRIVE_W - 1){!sum[SUM_W-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (move_s4) begin
			drive_q <= sat;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	`PFPL_ASSERT(a_stall_only_full,
		req_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && drive_valid_q &&
			drive_stall),
		"request stalled while the pipeline had room")
	`PFPL_ASSERT(a_restart_no_flip,
		(valid_s3 && prod_s3.restart) |-> !prod_s3.flip,
		"sign change seen on a restart tick")
	`PFPL_ASSERT(a_term_i_range,
		valid_s4 |-> ((term_s4.i <= int_t'(INT_LIMIT)) && (term_s4.i >= -int_t'(INT_LIMIT))),
		"integral term outside its clamp range")

endmodule

// File: rtl/core/pfpl_apb.sv
// Gain registers of the position loop behind an APB-style write and read port.
// Depends on pfpl_pkg.
module pfpl_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfpl_pkg::ADDR_W-1:0]  paddr,
	input  logic [pfpl_pkg::DATA_W-1:0]  pwdata,
	output logic [pfpl_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pfpl_pkg::gains_t             gains
);
	import pfpl_pkg::*;

	gains_t     gains_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	gain_t      wr_val;
	gain_t      rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_val  = pwdata[GAIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAIN_FF: gains_q.ff <= wr_val;
				REG_GAIN_P:  gains_q.p  <= wr_val;
				REG_GAIN_I:  gains_q.i  <= wr_val;
				REG_GAIN_D:  gains_q.d  <= wr_val;
				default:     gains_q    <= gains_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN_FF: rd_val = gains_q.ff;
			REG_GAIN_P:  rd_val = gains_q.p;
			REG_GAIN_I:  rd_val = gains_q.i;
			REG_GAIN_D:  rd_val = gains_q.d;
			default:     rd_val = '0;
		endcase
	end

	assign prdata = {{(DATA_W - GAIN_W){1'b0}}, rd_val};
	assign gains  = gains_q;

endmodule

// File: rtl/core/pfpl_err.sv
// Error stage: position and velocity errors, derivative difference and sign-change test.
// Holds the previous position error; depends on pfpl_pkg.
module pfpl_err (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  pfpl_pkg::sig_t        target_position,
	input  pfpl_pkg::sig_t        target_velocity,
	input  pfpl_pkg::sig_t        measured_position,
	input  pfpl_pkg::sig_t        measured_velocity,
	input  logic                  restart,
	output pfpl_pkg::err_stage_t  err_s2
);
	import pfpl_pkg::*;

	perr_t pe_q;
	perr_t pe_eff;
	perr_t e;
	perr_t ve;
	diff_t diff;
	logic  flip;

	assign e      = ERR_W'(target_position) - ERR_W'(measured_position);
	assign ve     = ERR_W'(target_velocity) - ERR_W'(measured_velocity);
	assign pe_eff = restart ? '0 : pe_q;
	assign diff   = DIFF_W'(e) - DIFF_W'(pe_eff);

	// A zero error on either side never counts as a sign change.
	assign flip = ((!e[ERR_W-1] && (e != '0)) && pe_eff[ERR_W-1]) ||
		(e[ERR_W-1] && (!pe_eff[ERR_W-1] && (pe_eff != '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_q <= '0;
		end else if (en) begin
			pe_q <= e;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2.e       <= e;
			err_s2.ve      <= ve;
			err_s2.diff    <= diff;
			err_s2.flip    <= flip;
			err_s2.restart <= restart;
		end
	end

endmodule

// File: rtl/core/pfpl_mul.sv
// Product stage: the four gain by signal multiplications, registered at full width.
// Depends on pfpl_pkg.
module pfpl_mul (
	input  logic                   clk,
	input  logic                   en,
	input  pfpl_pkg::gains_t       gains,
	input  pfpl_pkg::err_stage_t   err_s2,
	output pfpl_pkg::prod_stage_t  prod_s3
);
	import pfpl_pkg::*;

	prod_t p_ff;
	prod_t p_p;
	prod_t p_i;
	prod_t p_d;

	assign p_ff = PROD_W'(gains.ff) * PROD_W'(err_s2.ve);
	assign p_p  = PROD_W'(gains.p) * PROD_W'(err_s2.e);
	assign p_i  = PROD_W'(gains.i) * PROD_W'(err_s2.e);
	assign p_d  = PROD_W'(gains.d) * PROD_W'(err_s2.diff);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3.ff      <= p_ff;
			prod_s3.p       <= p_p;
			prod_s3.i       <= p_i;
			prod_s3.d       <= p_d;
			prod_s3.flip    <= err_s2.flip;
			prod_s3.restart <= err_s2.restart;
		end
	end

endmodule

// File: rtl/core/pfpl_intg.sv
// Rounding of the four terms and the clamped integral accumulator.
// Holds the integral sum; depends on pfpl_pkg and the assertion macros.
`include "pid_feedforward_position_loop_assert.svh"

module pfpl_intg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  pfpl_pkg::prod_stage_t  prod_s3,
	output pfpl_pkg::term_stage_t  term_s4
);
	import pfpl_pkg::*;

	localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(INT_LIMIT);
	localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

	int_t                     isum_q;
	int_t                     isum_eff;
	term_t                    ri;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_c;
	int_t                     i_next;

	assign isum_eff = prod_s3.restart ? '0 : isum_q;
	assign ri       = round_q8(prod_s3.i);
	assign acc      = ACC_W'(ri) + ACC_W'(isum_eff);

	always_comb begin
		if (acc > LIM_HI) begin
			acc_c = LIM_HI;
		end else if (acc < LIM_LO) begin
			acc_c = LIM_LO;
		end else begin
			acc_c = acc;
		end
	end

	// The integral is dropped when the error changes sign.
	assign i_next = prod_s3.flip ? '0 : acc_c[INT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q <= '0;
		end else if (en) begin
			isum_q <= i_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s4.ff <= round_q8(prod_s3.ff);
			term_s4.p  <= round_q8(prod_s3.p);
			term_s4.d  <= round_q8(prod_s3.d);
			term_s4.i  <= i_next;
		end
	end

	`PFPL_ASSERT(a_isum_range,
		(isum_q <= int_t'(INT_LIMIT)) && (isum_q >= -int_t'(INT_LIMIT)),
		"integral sum left its clamp range")

endmodule
